/* sv/nsv_pkg.sv */
// ----------------------------------------------------------------------------
// nsv_pkg
// Types, constants and helper functions shared by the sentence validator.
// ----------------------------------------------------------------------------
package nsv_pkg;

    localparam int unsigned HEAD_LEN = 6;
    localparam int unsigned TAIL_LEN = 3;
    localparam int unsigned HIST_LEN = 3;
    localparam logic [3:0]  POS_MAX  = 4'd15;
    localparam logic [3:0]  LONG_POS = 4'd8;

    // Sentence bytes are stored first byte at index 0, so the header
    // constants are written with their characters in reverse order.
    typedef logic [HEAD_LEN-1:0][7:0] head_t;
    typedef logic [TAIL_LEN-1:0][7:0] tail_t;
    typedef logic [HIST_LEN-1:0][7:0] hist_t;

    localparam head_t HDR_INACC = "CCANI$";
    localparam head_t HDR_GPRMC = "CMRPG$";
    localparam head_t HDR_GNRMC = "CMRNG$";
    localparam head_t HDR_GPGGA = "AGGPG$";
    localparam head_t HDR_GNGGA = "AGGNG$";

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;

    typedef enum logic [2:0] {
        VERDICT_RMC       = 3'd0,
        VERDICT_GGA       = 3'd1,
        VERDICT_OTHER     = 3'd2,
        VERDICT_INACC     = 3'd3,
        VERDICT_BAD_FRAME = 3'd4,
        VERDICT_BAD_SUM   = 3'd5
    } verdict_t;

    typedef struct packed {
        head_t      head;
        tail_t      tail;
        logic       long_ok;
        logic [7:0] csum;
    } frame_t;

    // Bit 4 of the result is set when the byte is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= "0" && c <= "9")
        begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
        begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

/* sv/nsv_in_if.sv */
// ----------------------------------------------------------------------------
// nsv_in_if
// Character channel: one sentence byte per beat, with an end flag.
// ----------------------------------------------------------------------------
interface nsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/nsv_out_if.sv */
// ----------------------------------------------------------------------------
// nsv_out_if
// Verdict channel: one result per sentence beat.
// ----------------------------------------------------------------------------
interface nsv_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;

    modport source (output valid, output verdict, output computed_sum,
                    output received_sum, input ready);
    modport sink   (input valid, input verdict, input computed_sum,
                    input received_sum, output ready);
endinterface

/* sv/nmea_sentence_validator_top.sv */
// Path: the final byte loads the frame register, then the result register.
// Throughput: one byte per cycle; the frame and result registers form a two-slot
// pipeline, so a stalled result blocks input only once both slots are full.
// Reset: rst_n clears the sentence state and both valid flags asynchronously.
// ----------------------------------------------------------------------------
// nmea_sentence_validator_top
// NMEA 0183 sentence checker: framing, checksum and sentence class.
// ----------------------------------------------------------------------------
module nmea_sentence_validator_top
    import nsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    nsv_in_if.sink     sentence,
    nsv_out_if.source  result
);

    logic   accept;
    logic   frame_valid;
    logic   frame_take;
    logic   judge_busy;
    frame_t frame;

    assign frame_take     = frame_valid && !judge_busy;
    assign sentence.ready = !frame_valid || frame_take;
    assign accept         = sentence.valid && sentence.ready;

    nsv_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (sentence.data_byte),
        .last_byte   (sentence.last_byte),
        .frame_take  (frame_take),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    nsv_judge u_judge (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_take (frame_take),
        .frame      (frame),
        .busy       (judge_busy),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_final_fills_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sentence.last_byte |=> frame_valid)
        else $error("final byte beat did not load the frame register");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && judge_busy |-> !sentence.ready)
        else $error("input ready while both pipeline slots are full");

    a_unchecked_sums_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.verdict == VERDICT_BAD_FRAME
                         || result.verdict == VERDICT_INACC)
        |-> result.computed_sum == 8'd0 && result.received_sum == 8'd0)
        else $error("sums not zero for an unchecked sentence");
`endif

endmodule

/* sv/nsv_tracker.sv */
// ----------------------------------------------------------------------------
// nsv_tracker
// Collects header, tail, length and running XOR of the current sentence and
// hands a frame snapshot to the judge on the final byte.
// ----------------------------------------------------------------------------
module nsv_tracker
    import nsv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   accept,
    input  logic [7:0] data_byte,
    input  logic   last_byte,
    input  logic   frame_take,
    output logic   frame_valid,
    output frame_t frame
);

    logic [3:0] pos_reg, pos_next;
    head_t      head_reg, head_next;
    tail_t      tail_reg, tail_next;
    logic [7:0] xor_reg, xor_next;
    hist_t      hist_reg, hist_next;
    logic       frame_valid_reg, frame_valid_next;
    frame_t     frame_reg;

    always_comb
    begin
        hist_next = {hist_reg[1:0], xor_reg};
        xor_next  = (pos_reg != 4'd0) ? (xor_reg ^ data_byte) : xor_reg;
        head_next = head_reg;
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            if (pos_reg == 4'(i))
            begin
                head_next[i] = data_byte;
            end
        end
        tail_next = {data_byte, tail_reg[2:1]};
        pos_next  = (pos_reg < POS_MAX) ? (pos_reg + 4'd1) : pos_reg;
    end

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        if (accept && last_byte)
        begin
            frame_valid_next = 1'b1;
        end
        else if (frame_take)
        begin
            frame_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            xor_reg         <= '0;
            hist_reg        <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            frame_valid_reg <= frame_valid_next;
            if (accept)
            begin
                if (last_byte)
                begin
                    pos_reg  <= '0;
                    head_reg <= '0;
                    tail_reg <= '0;
                    xor_reg  <= '0;
                    hist_reg <= '0;
                end
                else
                begin
                    pos_reg  <= pos_next;
                    head_reg <= head_next;
                    tail_reg <= tail_next;
                    xor_reg  <= xor_next;
                    hist_reg <= hist_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            frame_reg.head    <= head_next;
            frame_reg.tail    <= tail_next;
            frame_reg.long_ok <= (pos_reg >= LONG_POS);
            frame_reg.csum    <= hist_next[2];
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

/* sv/nsv_judge.sv */
// ----------------------------------------------------------------------------
// nsv_judge
// Checks a sentence frame and holds the verdict in the result register.
// ----------------------------------------------------------------------------
module nsv_judge
    import nsv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   frame_take,
    input  frame_t frame,
    output logic   busy,
    nsv_out_if.source result
);

    logic       valid_reg, valid_next;
    verdict_t   verdict_reg, verdict_next;
    logic [7:0] csum_reg, csum_next;
    logic [7:0] rsum_reg, rsum_next;
    logic [4:0] hi, lo;
    logic       is_inacc, bad_frame, is_rmc, is_gga;

    always_comb
    begin
        hi        = hex_val(frame.tail[1]);
        lo        = hex_val(frame.tail[2]);
        is_inacc  = (frame.head == HDR_INACC);
        is_rmc    = (frame.head == HDR_GPRMC) || (frame.head == HDR_GNRMC);
        is_gga    = (frame.head == HDR_GPGGA) || (frame.head == HDR_GNGGA);
        bad_frame = !frame.long_ok || (frame.head[0] != CHAR_DOLLAR)
                    || (frame.head[1] != CHAR_G) || (frame.tail[0] != CHAR_STAR);
        csum_next = '0;
        rsum_next = '0;
        priority if (is_inacc)
        begin
            verdict_next = VERDICT_INACC;
        end
        else if (bad_frame)
        begin
            verdict_next = VERDICT_BAD_FRAME;
        end
        else if (hi[4] || lo[4])
        begin
            csum_next    = frame.csum;
            verdict_next = VERDICT_BAD_SUM;
        end
        else
        begin
            csum_next = frame.csum;
            rsum_next = {hi[3:0], lo[3:0]};
            priority if (rsum_next != frame.csum)
            begin
                verdict_next = VERDICT_BAD_SUM;
            end
            else if (is_rmc)
            begin
                verdict_next = VERDICT_RMC;
            end
            else if (is_gga)
            begin
                verdict_next = VERDICT_GGA;
            end
            else
            begin
                verdict_next = VERDICT_OTHER;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (frame_take)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            verdict_reg <= verdict_next;
            csum_reg    <= csum_next;
            rsum_reg    <= rsum_next;
        end
    end

    assign busy                = valid_reg && !result.ready;
    assign result.valid        = valid_reg;
    assign result.verdict      = verdict_reg;
    assign result.computed_sum = csum_reg;
    assign result.received_sum = rsum_reg;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NMEA sentence validator. Sentences are sent one
// character per beat: a directed set covering every verdict and the edge
// lengths, then random sentences, mostly well formed with random content.
// A predictor tracks the sentence state and queues the expected verdict for
// each final character; every result beat is checked against that queue.
// ----------------------------------------------------------------------------
module tb_top;
    import nsv_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int TARGET_BEATS = 1100;
    localparam int QUIET_BEATS  = 150;
    localparam int LONG_HOLD    = 300;
    localparam int MIN_SENTENCE = 9;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [7:0] char_list_t[$];

    typedef struct {
        logic [7:0] data;
        logic       fin;
        bit         drain_first;
        bit         quiet;
    } char_beat_t;

    typedef struct {
        verdict_t   verdict;
        logic [7:0] computed;
        logic [7:0] received;
    } verdict_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    nsv_in_if  sentence_if ();
    nsv_out_if result_if ();

    nmea_sentence_validator_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .sentence (sentence_if),
        .result   (result_if)
    );

    char_beat_t   char_queue[$];
    verdict_rec_t verdicts_due[$];

    logic [3:0] chars_seen;
    head_t      first_chars;
    tail_t      last_chars;
    logic [7:0] sum_so_far;
    hist_t      sum_trail;

    int cycle_count = 0;
    int beats_in = 0;
    int verdicts_out = 0;
    int mismatches = 0;
    int class_count[6];
    int hold_at = 32'h7fffffff;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit quiet_phase = 1'b0;

    char_beat_t   next_beat;
    verdict_rec_t fresh_rec;
    verdict_rec_t due_rec;
    bit           fresh_valid;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int idle_pick();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 48;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 55;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 87;
        return -1;
    endfunction

    function automatic void clear_sentence();
        chars_seen  = '0;
        first_chars = '0;
        last_chars  = '0;
        sum_so_far  = '0;
        sum_trail   = '0;
    endfunction

    function automatic void validate_char(input logic [7:0] c, input logic fin,
                                          output bit gives, output verdict_rec_t rec);
        int len;
        int hi;
        int lo;
        logic [7:0] rsum;
        sum_trail = {sum_trail[1], sum_trail[0], sum_so_far};
        if (chars_seen != 0)
            sum_so_far = sum_so_far ^ c;
        if (chars_seen < HEAD_LEN)
            first_chars[chars_seen] = c;
        last_chars = {c, last_chars[2], last_chars[1]};
        len = int'(chars_seen) + 1;
        if (chars_seen != POS_MAX)
            chars_seen = chars_seen + 4'd1;
        gives = fin;
        rec.verdict  = VERDICT_BAD_FRAME;
        rec.computed = '0;
        rec.received = '0;
        if (!fin)
            return;
        if (first_chars == HDR_INACC)
            rec.verdict = VERDICT_INACC;
        else if (len < MIN_SENTENCE || first_chars[0] != CHAR_DOLLAR
                 || first_chars[1] != CHAR_G || last_chars[0] != CHAR_STAR)
            rec.verdict = VERDICT_BAD_FRAME;
        else
        begin
            rec.computed = sum_trail[2];
            hi = nibble_of(last_chars[1]);
            lo = nibble_of(last_chars[2]);
            if (hi < 0 || lo < 0)
                rec.verdict = VERDICT_BAD_SUM;
            else
            begin
                rsum = 8'(hi * 16 + lo);
                rec.received = rsum;
                if (rsum != rec.computed)
                    rec.verdict = VERDICT_BAD_SUM;
                else if (first_chars == HDR_GPRMC || first_chars == HDR_GNRMC)
                    rec.verdict = VERDICT_RMC;
                else if (first_chars == HDR_GPGGA || first_chars == HDR_GNGGA)
                    rec.verdict = VERDICT_GGA;
                else
                    rec.verdict = VERDICT_OTHER;
            end
        end
        clear_sentence();
    endfunction

    function automatic char_list_t text(input string s);
        char_list_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic char_list_t random_chars(input int n);
        char_list_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic char_list_t seal(input char_list_t body, input logic [1:0] lower);
        char_list_t q;
        logic [7:0] sum;
        sum = '0;
        q.push_back(CHAR_DOLLAR);
        foreach (body[i])
        begin
            q.push_back(body[i]);
            sum = sum ^ body[i];
        end
        q.push_back(CHAR_STAR);
        q.push_back(hex_char(sum[7:4], lower[1]));
        q.push_back(hex_char(sum[3:0], lower[0]));
        return q;
    endfunction

    function automatic void queue_sentence(input char_list_t q);
        char_beat_t b;
        foreach (q[i])
        begin
            b.data        = q[i];
            b.fin         = (i == q.size() - 1);
            b.drain_first = 1'b0;
            b.quiet       = 1'b0;
            char_queue.push_back(b);
        end
    endfunction

    function automatic char_list_t random_header();
        char_list_t q;
        char_list_t picks;
        picks = text("RMCGA");
        case ($urandom_range(0, 5))
            0: q = text("GPRMC");
            1: q = text("GNRMC");
            2: q = text("GPGGA");
            3: q = text("GNGGA");
            4:
            begin
                q = text("G");
                repeat ($urandom_range(0, 6))
                    q.push_back(8'($urandom_range(8'h41, 8'h5a)));
            end
            default:
            begin
                q = text("G");
                q.push_back($urandom_range(0, 1) ? 8'h50 : 8'h4e);
                repeat (3)
                    q.push_back(picks[$urandom_range(0, 4)]);
            end
        endcase
        return q;
    endfunction

    function automatic char_list_t random_sentence();
        char_list_t q;
        int kind;
        int n;
        int idx;
        kind = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 20);
        if (kind < 80)
        begin
            q = seal({random_header(), random_chars(n)}, 2'($urandom_range(0, 3)));
            if (kind >= 62 && kind < 72)
            begin
                idx = $urandom_range(0, q.size() - 1);
                q[idx] = q[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (kind >= 72)
            begin
                idx = q.size() - 1 - $urandom_range(0, 1);
                q[idx] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                                   : hex_char(4'($urandom_range(0, 15)), 1'b0);
            end
        end
        else if (kind < 88)
            q = {text("$INACC"), random_chars($urandom_range(0, 10))};
        else if (kind < 94)
            q = {text("$G"), random_chars($urandom_range(0, 12))};
        else
            q = random_chars($urandom_range(1, 20));
        return q;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sentence_if.valid     <= 1'b0;
            sentence_if.data_byte <= '0;
            sentence_if.last_byte <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (sentence_if.valid && sentence_if.ready)
            begin
                validate_char(sentence_if.data_byte, sentence_if.last_byte,
                              fresh_valid, fresh_rec);
                if (fresh_valid)
                    verdicts_due.push_back(fresh_rec);
                beats_in++;
            end
            if (!sentence_if.valid || sentence_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sentence_if.valid <= 1'b0;
                end
                else if (char_queue.size() == 0)
                    sentence_if.valid <= 1'b0;
                else if (char_queue[0].drain_first && verdicts_due.size() != 0)
                    sentence_if.valid <= 1'b0;
                else if (!char_queue[0].quiet && $urandom_range(0, 99) < send_idle_pct)
                begin
                    gap_left = $urandom_range(0, 8);
                    sentence_if.valid <= 1'b0;
                end
                else
                begin
                    next_beat = char_queue.pop_front();
                    quiet_phase = next_beat.quiet;
                    if (next_beat.fin)
                        send_idle_pct = idle_pick();
                    sentence_if.valid     <= 1'b1;
                    sentence_if.data_byte <= next_beat.data;
                    sentence_if.last_byte <= next_beat.fin;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && beats_in >= hold_at)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                verdicts_out++;
                if (result_if.verdict < 3'd6)
                    class_count[result_if.verdict]++;
                recv_idle_pct = idle_pick();
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected verdict beat: %0d sums %02h/%02h",
                                 result_if.verdict, result_if.computed_sum,
                                 result_if.received_sum);
                end
                else
                begin
                    due_rec = verdicts_due.pop_front();
                    if (result_if.verdict !== due_rec.verdict
                        || result_if.computed_sum !== due_rec.computed
                        || result_if.received_sum !== due_rec.received)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Verdict %0d: expected %0d %02h/%02h, got %0d %02h/%02h",
                                     verdicts_out, due_rec.verdict, due_rec.computed,
                                     due_rec.received, result_if.verdict,
                                     result_if.computed_sum, result_if.received_sum);
                    end
                end
            end
            if (hold_left > 0)
                result_if.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(0, 8);
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int directed_beats;
        char_list_t long_body;
        rst_n = 1'b0;
        sentence_if.valid     = 1'b0;
        sentence_if.data_byte = '0;
        sentence_if.last_byte = 1'b0;
        result_if.ready       = 1'b0;
        foreach (class_count[i])
            class_count[i] = 0;
        clear_sentence();

        queue_sentence(seal(text("GPRMC,123519,A,4807.038,N"), 2'b00));
        queue_sentence(seal(text("GNRMC,,V"), 2'b11));
        queue_sentence(seal(text("GPGGA,1,2"), 2'b10));
        queue_sentence(seal(text("GNGGA"), 2'b01));
        queue_sentence(seal(text("GPGSV,3,1"), 2'b00));
        queue_sentence(text("$INACC"));
        queue_sentence(text("$INACC,12*ZZ"));
        queue_sentence(text("$INAC"));
        queue_sentence(text("$"));
        queue_sentence(seal(text("GABC"), 2'b00));
        queue_sentence(seal(text("GABCD"), 2'b00));
        queue_sentence(seal({text("GPGSV,"), 8'h00, 8'hff, 8'h80, text(",1")}, 2'b01));
        long_body = {text("GPRMC,"), random_chars(70)};
        queue_sentence(seal(long_body, 2'b00));
        queue_sentence(text("$GPGGA,1*00"));
        queue_sentence(text("$GPGSA,1*4G"));
        queue_sentence(text("$GPGSA,1*g4"));
        queue_sentence(text("$GPRMC,123,A"));
        queue_sentence(text("!GPGGA,1*00"));
        queue_sentence(seal(text("XPRMC,1"), 2'b00));
        queue_sentence({8'hff, 8'h00, 8'h2a, 8'h30, 8'h30});

        directed_beats = char_queue.size();
        while (char_queue.size() < TARGET_BEATS)
            queue_sentence(random_sentence());
        char_queue[directed_beats].drain_first = 1'b1;
        for (int i = char_queue.size() - QUIET_BEATS; i < char_queue.size(); i++)
            char_queue[i].quiet = 1'b1;
        char_queue[char_queue.size() - QUIET_BEATS].drain_first = 1'b1;
        hold_at = directed_beats + 200;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_queue.size() != 0 || sentence_if.valid || verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d character beats; checked %0d verdicts.", beats_in, verdicts_out);
        $display("RMC %0d, GGA %0d, other %0d, bypass %0d, bad frame %0d, bad checksum %0d.",
                 class_count[0], class_count[1], class_count[2], class_count[3],
                 class_count[4], class_count[5]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
sv/nsv_pkg.sv
sv/nsv_in_if.sv
sv/nsv_out_if.sv
sv/nsv_tracker.sv
sv/nsv_judge.sv
sv/nmea_sentence_validator_top.sv
verif/tb_top.sv
